[src/bpp_pkg.sv]
// Shared constants, types and helper functions of the bimodal branch predictor.
package bpp_pkg;

  localparam int MAX_INDEX_BITS = 12;
  localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
  localparam int CFG_W          = 4;
  localparam int ADDR_W         = 32;
  localparam int COUNT_W        = 32;

  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(12);

  typedef logic [MAX_INDEX_BITS-1:0] tbl_idx_t;

  // Two-bit hysteresis counter codes.
  typedef enum logic [1:0] {
    CTR_SN = 2'b00,
    CTR_WN = 2'b01,
    CTR_WT = 2'b10,
    CTR_ST = 2'b11
  } ctr_t;

  typedef enum logic {
    PS_CLEAR,
    PS_RUN
  } pred_state_t;

  // Table index from the low address bits, width limited to the table size.
  function automatic tbl_idx_t table_index(input logic [ADDR_W-1:0] addr,
                                           input logic [CFG_W-1:0]  width);
    tbl_idx_t idx;
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      idx[i] = addr[i] & (32'(width) > i);
    end
    return idx;
  endfunction

  function automatic ctr_t ctr_update(input ctr_t cur, input logic tk);
    ctr_t nxt;
    if (tk) begin
      nxt = (cur == CTR_SN) ? CTR_WN : CTR_ST;
    end else begin
      nxt = (cur == CTR_ST) ? CTR_WT : CTR_SN;
    end
    return nxt;
  endfunction

endpackage

[src/bpp_if.sv]
// Valid/ready channel interfaces for branch transactions and prediction results.
interface bpp_branch_if;
  logic                           valid;
  logic                           ready;
  logic [bpp_pkg::ADDR_W-1:0]     branch_address;
  logic                           taken;

  modport source (output valid, output branch_address, output taken, input ready);
  modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface bpp_result_if;
  logic                           valid;
  logic                           ready;
  logic                           prediction;
  logic                           mispredicted;
  logic [bpp_pkg::COUNT_W-1:0]    miss_count;

  modport source (output valid, output prediction, output mispredicted,
                  output miss_count, input ready);
  modport sink   (input valid, input prediction, input mispredicted,
                  input miss_count, output ready);
endinterface

[src/bimodal_branch_predictor.sv]
// Top level of the bimodal branch predictor with two-bit hysteresis counters.
//
//   Channel     Dir  Contents
//   branch_in   in   branch_address[31:0], taken
//   result_out  out  prediction, mispredicted, miss_count[31:0]
//   cfg_wr_*    in   index_bits[3:0], written when cfg_wr_en is high
//
// One branch transaction is taken per cycle unless the result stalls, and passes
// the read stage into the output register. The counter table is a one-port-read,
// one-port-write RAM read on acceptance and written back as the branch leaves the
// read stage, with the write forwarded to a read of the same entry in that cycle.
// After reset a clearing pass sets every counter to strong taken, and no branch is
// taken meanwhile. A stalled result holds the pending branch and so the input side.
module bimodal_branch_predictor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bpp_pkg::CFG_W-1:0]   cfg_wr_data,
  bpp_branch_if.sink                  branch_in,
  bpp_result_if.source                result_out
);

  bpp_pkg::pred_state_t state, state_next;
  bpp_pkg::tbl_idx_t    clear_addr, clear_addr_next;

  logic [bpp_pkg::CFG_W-1:0]   index_bits;
  logic [bpp_pkg::COUNT_W-1:0] miss_total;

  // Second stage: branch whose counter is being read.
  logic                 s1_valid;
  bpp_pkg::tbl_idx_t    s1_index;
  logic                 s1_taken;
  logic                 s1_fwd;
  bpp_pkg::ctr_t        s1_fwd_data;

  logic                 in_acc;
  logic                 s1_adv;
  bpp_pkg::tbl_idx_t    in_index;
  logic [1:0]           ram_rd_data;
  bpp_pkg::ctr_t        cur_ctr;
  bpp_pkg::ctr_t        new_ctr;
  logic                 pred;
  logic                 miss;
  logic                 ram_we;
  bpp_pkg::tbl_idx_t    ram_wr_addr;
  bpp_pkg::ctr_t        ram_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpp_pkg::PS_CLEAR;
      clear_addr <= '0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
    end
  end

  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    case (state)
      bpp_pkg::PS_CLEAR: begin
        clear_addr_next = clear_addr + 1'b1;
        if (clear_addr == bpp_pkg::tbl_idx_t'(bpp_pkg::TABLE_DEPTH - 1)) begin
          state_next = bpp_pkg::PS_RUN;
        end
      end
      bpp_pkg::PS_RUN: begin
        state_next = bpp_pkg::PS_RUN;
      end
      default: begin
        state_next = bpp_pkg::PS_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= bpp_pkg::INDEX_BITS_RESET;
    end else if (cfg_wr_en) begin
      index_bits <= cfg_wr_data;
    end
  end

  assign s1_adv          = s1_valid && (!result_out.valid || result_out.ready);
  assign branch_in.ready = (state == bpp_pkg::PS_RUN) && (!s1_valid || s1_adv);
  assign in_acc          = branch_in.valid && branch_in.ready;
  assign in_index        = bpp_pkg::table_index(branch_in.branch_address, index_bits);

  assign cur_ctr = s1_fwd ? s1_fwd_data : bpp_pkg::ctr_t'(ram_rd_data);
  assign pred    = (cur_ctr == bpp_pkg::CTR_WT) || (cur_ctr == bpp_pkg::CTR_ST);
  assign miss    = pred != s1_taken;
  assign new_ctr = bpp_pkg::ctr_update(cur_ctr, s1_taken);

  assign ram_we      = (state == bpp_pkg::PS_CLEAR) || s1_adv;
  assign ram_wr_addr = (state == bpp_pkg::PS_CLEAR) ? clear_addr : s1_index;
  assign ram_wr_data = (state == bpp_pkg::PS_CLEAR) ? bpp_pkg::CTR_ST : new_ctr;

  bpp_ram #(
    .WIDTH (2),
    .DEPTH (bpp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_index),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The RAM returns the old value when it is written and read at the same entry in
  // one cycle, so the written counter is captured here instead.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_index    <= in_index;
      s1_taken    <= branch_in.taken;
      s1_fwd      <= s1_adv && (s1_index == in_index);
      s1_fwd_data <= new_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_total <= '0;
    end else if (s1_adv && miss && (miss_total != '1)) begin
      miss_total <= miss_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (s1_adv) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_out.prediction   <= pred;
      result_out.mispredicted <= miss;
      result_out.miss_count   <= (miss && (miss_total != '1)) ? miss_total + 1'b1
                                                              : miss_total;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == bpp_pkg::PS_CLEAR) |-> !branch_in.ready)
    else $error("branch accepted during the table clearing pass");

  a_forward_capture: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s1_adv && (s1_index == in_index)) |=> s1_fwd)
    else $error("same-entry write-back was not forwarded");

  a_result_after_adv: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_out.valid)
    else $error("completed branch produced no result");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (miss_total >= $past(miss_total)))
    else $error("miss count decreased");

endmodule

[src/bpp_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module bpp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the bimodal branch predictor with two-bit counters.
`timescale 1ns / 100ps

module tb;
  import bpp_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic               prediction;
    logic               mispredicted;
    logic [COUNT_W-1:0] miss_count;
  } branch_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  bpp_branch_if br_if ();
  bpp_result_if res_if ();

  bimodal_branch_predictor u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .branch_in  (br_if),
    .result_out (res_if)
  );

  // Own copy of the predictor state.
  ctr_t               model_table [TABLE_DEPTH];
  logic [COUNT_W-1:0] model_misses;
  logic [CFG_W-1:0]   model_index_bits;

  branch_result_t expected_results [$];
  int unsigned    error_count;
  int unsigned    hold_off_left;
  bit             no_idle;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic branch_result_t predict_branch(input logic [ADDR_W-1:0] addr,
                                                    input logic tk);
    int unsigned                w;
    logic [MAX_INDEX_BITS-1:0]  idx;
    ctr_t                       cur;
    branch_result_t             r;
    w   = (model_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : model_index_bits;
    idx = MAX_INDEX_BITS'(addr & ((32'd1 << w) - 32'd1));
    cur = model_table[idx];
    r.prediction   = (cur == CTR_WT) || (cur == CTR_ST);
    r.mispredicted = (r.prediction != tk);
    if (tk) begin
      model_table[idx] = (cur == CTR_SN) ? CTR_WN : CTR_ST;
    end else begin
      model_table[idx] = (cur == CTR_ST) ? CTR_WT : CTR_SN;
    end
    if (r.mispredicted && model_misses != '1) begin
      model_misses = model_misses + 1'b1;
    end
    r.miss_count = model_misses;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned rand_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic tk);
    int unsigned gap;
    gap = rand_gap();
    @(negedge clk);
    if (gap > 0) begin
      br_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    br_if.valid          <= 1'b1;
    br_if.branch_address <= addr;
    br_if.taken          <= tk;
    do begin
      @(posedge clk);
    end while (!br_if.ready);
    expected_results.push_back(predict_branch(addr, tk));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    br_if.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_index_bits(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_index_bits = value;
  endtask

  // Walks one entry through every counter state, using the reset width.
  task automatic test_counter_walk();
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h0000_1FFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_F000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
  endtask

  // Zero width, widths beyond the table and a change that keeps the table.
  task automatic test_index_width();
    write_index_bits(4'd0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h1234_5678, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    write_index_bits(4'd15);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hABCD_E000, 1'b0);
    write_index_bits(4'd13);
    send_branch(32'h0000_0FFF, 1'b1);
    send_branch(32'h5555_5AAA, 1'b0);
    write_index_bits(4'd1);
    send_branch(32'h0000_0001, 1'b0);
    send_branch(32'hFFFF_FFFE, 1'b0);
    write_index_bits(4'd12);
    send_branch(32'hAAAA_AFFF, 1'b1);
  endtask

  // The receiver holds off while the sender keeps offering back-to-back.
  task automatic test_back_pressure();
    int unsigned i;
    no_idle = 1'b1;
    hold_off_left = 150;
    for (i = 0; i < 60; i++) begin
      send_branch($urandom, 1'(i % 3 == 0));
    end
    drain_results();
    no_idle = 1'b0;
  endtask

  // Branches mostly come from a small pool with a per-branch bias, like real code.
  task automatic test_random_traffic(input int unsigned n_items, input logic [CFG_W-1:0] width);
    logic [ADDR_W-1:0] pool [16];
    int unsigned       bias [16];
    int unsigned       i;
    int unsigned       k;
    logic [ADDR_W-1:0] addr;
    logic              tk;
    write_index_bits(width);
    for (i = 0; i < 16; i++) begin
      pool[i] = $urandom;
      case ($urandom_range(0, 4))
        0: begin bias[i] = 0; end
        1: begin bias[i] = 5; end
        2: begin bias[i] = 50; end
        3: begin bias[i] = 95; end
        default: begin bias[i] = 100; end
      endcase
    end
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        k    = $urandom_range(0, 15);
        addr = pool[k];
        tk   = ($urandom_range(0, 99) < bias[k]);
      end else begin
        addr = $urandom;
        tk   = 1'($urandom_range(0, 1));
      end
      send_branch(addr, tk);
    end
  endtask

  // Receiver: random ready pattern, plus an explicit hold-off when requested.
  initial begin
    int unsigned wait_left;
    wait_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        res_if.ready <= 1'b0;
        hold_off_left = hold_off_left - 1;
      end else if (wait_left > 0) begin
        res_if.ready <= 1'b0;
        wait_left = wait_left - 1;
      end else begin
        res_if.ready <= 1'b1;
        wait_left = rand_gap();
      end
    end
  end

  // Each result transaction is compared against the oldest prediction.
  always @(posedge clk) begin
    branch_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        error_count = error_count + 1;
        $display("%0t: result with none pending: prediction %0b mispredicted %0b count %0d",
                 $time, res_if.prediction, res_if.mispredicted, res_if.miss_count);
      end else begin
        want = expected_results.pop_front();
        if (res_if.prediction !== want.prediction ||
            res_if.mispredicted !== want.mispredicted ||
            res_if.miss_count !== want.miss_count) begin
          error_count = error_count + 1;
          $display("%0t: expected pred %0b miss %0b count %0d, got pred %0b miss %0b count %0d",
                   $time, want.prediction, want.mispredicted, want.miss_count,
                   res_if.prediction, res_if.mispredicted, res_if.miss_count);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction; covers the clearing pass.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((br_if.valid && br_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    br_if.valid          = 1'b0;
    br_if.branch_address = '0;
    br_if.taken          = 1'b0;
    error_count          = 0;
    hold_off_left        = 0;
    no_idle              = 1'b0;
    model_misses         = '0;
    model_index_bits     = INDEX_BITS_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      model_table[i] = CTR_ST;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_counter_walk();
    test_index_width();
    test_back_pressure();
    test_random_traffic(250, 4'd0);
    test_random_traffic(250, 4'd3);
    test_random_traffic(250, 4'd12);
    no_idle = 1'b1;
    test_random_traffic(200, 4'd15);
    no_idle = 1'b0;
    test_random_traffic(250, 4'd7);
    test_random_traffic(200, 4'd1);
    test_random_traffic(200, 4'($urandom_range(0, 15)));
    drain_results();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bpp_pkg.sv
src/bpp_if.sv
src/bpp_ram.sv
src/bimodal_branch_predictor.sv
tb/tb.sv
